// ----- sv/mcsp_pkg.sv -----
// Shared types and constants for the MNG chunk stream parser.
package mcsp_pkg;

    localparam logic [31:0] TYPE_MHDR = 32'h4d48_4452;
    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4e44;
    localparam logic [31:0] TYPE_MEND = 32'h4d45_4e44;
    localparam logic [31:0] TYPE_FRAM = 32'h4652_414d;

    localparam logic [31:0] MS_PER_SECOND  = 32'd1000;
    localparam logic [31:0] CHUNK_OVERHEAD = 32'd12;

    // First data byte of the big-endian delay operand
    localparam logic [31:0] MHDR_TPS_OFFSET   = 32'd8;
    localparam logic [31:0] FRAM_DELAY_OFFSET = 32'd6;

    // Last byte index of a four-byte header or CRC field
    localparam logic [31:0] FIELD_LAST = 32'd3;

    localparam int DIV_WIDTH = 32;
    localparam int DIV_CNT_W = $clog2(DIV_WIDTH);

    typedef enum logic [1:0] {
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CRC
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIN,
        ST_DIVSTART,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic byte_en;    // accepted beat
        logic fin;        // chunk bookkeeping and delay operand product
        logic div_start;  // launch the divider
        logic div_zero;   // zero divisor: delay 0, flag error
        logic div_load;   // take quotient as delay
        logic emit;       // load the output register, rearm the parser
    } t_dp_cmd;

    typedef struct packed {
        logic chunk_end;  // current beat is the last CRC byte
        logic needs_div;  // chunk is MHDR or FRAM
        logic div_zero;   // ticks per second is zero
        logic div_done;   // quotient ready
        logic out_free;   // output register can take a result
    } t_dp_status;

endpackage

// ----- sv/mcsp_divider.sv -----
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
module mcsp_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic [31:0]                  r_quo;
    logic [31:0]                  r_rem;
    logic [31:0]                  r_div;
    logic [mcsp_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [32:0]                  trial;
    logic [32:0]                  diff;

    assign trial = {r_rem, r_quo[31]};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == mcsp_pkg::DIV_CNT_W'(mcsp_pkg::DIV_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!diff[32]) begin
                r_rem <= diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= trial[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- sv/mcsp_datapath.sv -----
// Chunk field registers, delay arithmetic and the result register.
module mcsp_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mcsp_pkg::t_dp_cmd    i_cmd,
    output mcsp_pkg::t_dp_status o_status,
    input  logic [7:0]           i_byte,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [31:0]          o_chunk_type,
    output logic [31:0]          o_chunk_length,
    output logic                 o_frame_done,
    output logic [31:0]          o_frame_delay_ms,
    output logic [31:0]          o_frame_number,
    output logic [31:0]          o_image_span_bytes,
    output logic                 o_stream_end,
    output logic                 o_divide_error
);

    mcsp_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_len, n_len;
    logic [31:0] r_type, n_type;
    logic [31:0] r_capt, n_capt;
    logic [31:0] r_tps, n_tps;
    logic [31:0] r_delay, n_delay;
    logic [31:0] r_frames, n_frames;
    logic [31:0] r_span, n_span;
    logic        r_ended, n_ended;
    logic        r_err, n_err;
    logic [31:0] r_scaled;
    logic        r_out_valid;

    logic [31:0] cap_first;
    logic [31:0] cap_diff;
    logic        cap_en;
    logic [31:0] cap_word;
    logic [31:0] pos_inc;
    logic [31:0] quotient;
    logic        div_done;
    logic [31:0] dividend;

    assign pos_inc  = r_pos + 32'd1;
    assign cap_first = (r_type == mcsp_pkg::TYPE_MHDR) ? mcsp_pkg::MHDR_TPS_OFFSET
                                                       : mcsp_pkg::FRAM_DELAY_OFFSET;
    assign cap_en   = (r_type == mcsp_pkg::TYPE_MHDR) || (r_type == mcsp_pkg::TYPE_FRAM);
    assign cap_diff = r_pos - cap_first;

    // Place the byte into its big-endian lane of the operand
    always_comb begin
        cap_word = r_capt;
        if (cap_en && (r_pos >= cap_first) && (cap_diff < 32'd4)) begin
            unique case (cap_diff[1:0])
                2'd0: cap_word[31:24] = r_capt[31:24] | i_byte;
                2'd1: cap_word[23:16] = r_capt[23:16] | i_byte;
                2'd2: cap_word[15:8]  = r_capt[15:8]  | i_byte;
                2'd3: cap_word[7:0]   = r_capt[7:0]   | i_byte;
            endcase
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_len    = r_len;
        n_type   = r_type;
        n_capt   = r_capt;
        n_tps    = r_tps;
        n_delay  = r_delay;
        n_frames = r_frames;
        n_span   = r_span;
        n_ended  = r_ended;
        n_err    = r_err;

        if (i_cmd.byte_en && !r_ended) begin
            unique case (r_phase)
                mcsp_pkg::PH_LEN: begin
                    n_len = {r_len[23:0], i_byte};
                    n_pos = pos_inc;
                    if (r_pos == mcsp_pkg::FIELD_LAST) begin
                        n_phase = mcsp_pkg::PH_TYPE;
                        n_pos   = '0;
                        n_type  = '0;
                    end
                end
                mcsp_pkg::PH_TYPE: begin
                    n_type = {r_type[23:0], i_byte};
                    n_pos  = pos_inc;
                    if (r_pos == mcsp_pkg::FIELD_LAST) begin
                        n_pos   = '0;
                        n_capt  = '0;
                        n_phase = (r_len == '0) ? mcsp_pkg::PH_CRC : mcsp_pkg::PH_DATA;
                    end
                end
                mcsp_pkg::PH_DATA: begin
                    n_capt = cap_word;
                    n_pos  = pos_inc;
                    if (pos_inc == r_len) begin
                        n_pos   = '0;
                        n_phase = mcsp_pkg::PH_CRC;
                    end
                end
                mcsp_pkg::PH_CRC: begin
                    // last CRC byte holds the position until the chunk is emitted
                    if (r_pos != mcsp_pkg::FIELD_LAST) begin
                        n_pos = pos_inc;
                    end
                end
            endcase
        end

        if (i_cmd.fin) begin
            n_err = 1'b0;
            if (r_type == mcsp_pkg::TYPE_IHDR) begin
                n_span = r_len + mcsp_pkg::CHUNK_OVERHEAD;
            end else begin
                n_span = r_span + r_len + mcsp_pkg::CHUNK_OVERHEAD;
            end
            if (r_type == mcsp_pkg::TYPE_MHDR) begin
                n_tps = r_capt;
            end
            if (r_type == mcsp_pkg::TYPE_IEND) begin
                n_frames = r_frames + 32'd1;
            end
            if (r_type == mcsp_pkg::TYPE_MEND) begin
                n_ended = 1'b1;
            end
        end

        if (i_cmd.div_zero) begin
            n_delay = '0;
            n_err   = 1'b1;
        end

        if (i_cmd.div_load) begin
            n_delay = quotient;
        end

        if (i_cmd.emit) begin
            n_phase = mcsp_pkg::PH_LEN;
            n_pos   = '0;
            n_len   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= mcsp_pkg::PH_LEN;
            r_pos    <= '0;
            r_len    <= '0;
            r_type   <= '0;
            r_capt   <= '0;
            r_tps    <= '0;
            r_delay  <= '0;
            r_frames <= '0;
            r_span   <= '0;
            r_ended  <= 1'b0;
            r_err    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_type   <= n_type;
            r_capt   <= n_capt;
            r_tps    <= n_tps;
            r_delay  <= n_delay;
            r_frames <= n_frames;
            r_span   <= n_span;
            r_ended  <= n_ended;
            r_err    <= n_err;
        end
    end

    // FRAM operand scaled to milliseconds, wrapped to 32 bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_scaled <= 32'(r_capt * mcsp_pkg::MS_PER_SECOND);
        end
    end

    assign dividend = (r_type == mcsp_pkg::TYPE_MHDR) ? mcsp_pkg::MS_PER_SECOND : r_scaled;

    mcsp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_tps),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_chunk_type       <= r_type;
            o_chunk_length     <= r_len;
            o_frame_done       <= (r_type == mcsp_pkg::TYPE_IEND);
            o_frame_delay_ms   <= r_delay;
            o_frame_number     <= r_frames;
            o_image_span_bytes <= r_span;
            o_stream_end       <= (r_type == mcsp_pkg::TYPE_MEND);
            o_divide_error     <= r_err;
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_status.chunk_end = !r_ended && (r_phase == mcsp_pkg::PH_CRC)
                                && (r_pos == mcsp_pkg::FIELD_LAST);
    assign o_status.needs_div = cap_en;
    assign o_status.div_zero  = (r_tps == '0);
    assign o_status.div_done  = div_done;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule

// ----- sv/mcsp_ctrl.sv -----
// Sequencer: byte intake, chunk finish, divide and result hand-off.
module mcsp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mcsp_pkg::t_dp_status i_status,
    output mcsp_pkg::t_dp_cmd    o_cmd
);

    mcsp_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcsp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;

        unique case (r_state)
            mcsp_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.byte_en = i_in_valid;
                if (i_in_valid && i_status.chunk_end) begin
                    n_state = mcsp_pkg::ST_FIN;
                end
            end
            mcsp_pkg::ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = mcsp_pkg::ST_DIVSTART;
            end
            mcsp_pkg::ST_DIVSTART: begin
                priority if (!i_status.needs_div) begin
                    n_state = mcsp_pkg::ST_EMIT;
                end else if (i_status.div_zero) begin
                    o_cmd.div_zero = 1'b1;
                    n_state        = mcsp_pkg::ST_EMIT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = mcsp_pkg::ST_DIV;
                end
            end
            mcsp_pkg::ST_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = mcsp_pkg::ST_EMIT;
                end
            end
            mcsp_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = mcsp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mcsp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/mng_chunk_stream_parser.sv -----
// MNG chunk stream parser top level: one byte per beat in, one result beat per chunk out.
// Bytes inside a chunk are taken one per cycle; after the last CRC byte intake pauses
// through the FIN and DIVSTART states, on MHDR/FRAM chunks with a nonzero divisor also
// while the delay goes through the 32-step serial divider, and in EMIT until the result
// register can take the result. Chunks after MEND give no result beat. Synchronous
// active-low reset clears the parser state and valid flag, not the result data.
module mng_chunk_stream_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    // Result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] chunk_type, [63:32] chunk_length, [95:64] frame_delay_ms,
    // [127:96] frame_number, [159:128] image_span_bytes
    output logic [159:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [0] frame_done, [1] divide_error
    output logic         m_axis_tlast    // stream_end: chunk was MEND
);

    mcsp_pkg::t_dp_cmd    cmd;
    mcsp_pkg::t_dp_status status;

    logic [31:0] chunk_type;
    logic [31:0] chunk_length;
    logic        frame_done;
    logic [31:0] frame_delay_ms;
    logic [31:0] frame_number;
    logic [31:0] image_span_bytes;
    logic        stream_end;
    logic        divide_error;

    // The controller owns the intake handshake; the datapath owns the result beat.
    mcsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mcsp_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_byte             (s_axis_tdata),
        .i_out_ready        (m_axis_tready),
        .o_out_valid        (m_axis_tvalid),
        .o_chunk_type       (chunk_type),
        .o_chunk_length     (chunk_length),
        .o_frame_done       (frame_done),
        .o_frame_delay_ms   (frame_delay_ms),
        .o_frame_number     (frame_number),
        .o_image_span_bytes (image_span_bytes),
        .o_stream_end       (stream_end),
        .o_divide_error     (divide_error)
    );

    // Pack the result beat, first field lowest
    assign m_axis_tdata = {image_span_bytes, frame_number, frame_delay_ms,
                           chunk_length, chunk_type};
    assign m_axis_tuser = {divide_error, frame_done};
    assign m_axis_tlast = stream_end;

endmodule
